// File: sv/rpps_pkg.sv
// Shared types, constants and comparison functions of the path point simplifier.
package rpps_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int COORD_BITS  = 24;
    localparam int ADDR_W      = $clog2(MAX_POINTS);
    localparam int CNT_W       = $clog2(MAX_POINTS + 1);
    localparam int IDX_W       = 10;
    localparam int COUNT_OUT_W = 11;
    localparam int KIND_W      = 2;
    localparam int ACTION_W    = 3;
    localparam int IN_DATA_W   = ((2 * COORD_BITS + IDX_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((COUNT_OUT_W + 2 * COORD_BITS + 1 + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [ACTION_W-1:0] ACT_APPENDED  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DUPLICATE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SEPARATOR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TRIMMED   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ELIDED    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_OVERFLOW  = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_CLEARED   = 3'd7;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        logic sep;
        logic spike;
        logic elide;
    } t_verdict;

    function automatic logic lies_between(input t_coord a, input t_coord b, input t_coord c);
        lies_between = (a < b) && (b < c);
    endfunction

    function automatic logic is_sep(input t_coord a0, input t_coord a1, input t_coord a2);
        is_sep = lies_between(a2, a1, a0) || lies_between(a0, a1, a2);
    endfunction

    function automatic logic is_trim(input t_coord a0, input t_coord a1, input t_coord a2);
        is_trim = lies_between(a1, a0, a2) || lies_between(a2, a0, a1) ||
                  lies_between(a1, a2, a0) || lies_between(a0, a2, a1);
    endfunction

    function automatic logic is_elide(input t_coord a0, input t_coord a1, input t_coord a2);
        is_elide = (a0 == a2) && (a0 != a1);
    endfunction

endpackage

// File: sv/rpps_stack_mem.sv
// Point stack storage: one write port and one registered read port.
module rpps_stack_mem (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [rpps_pkg::ADDR_W-1:0] i_waddr,
    input  rpps_pkg::t_point       i_wdata,
    input  logic                   i_re,
    input  logic [rpps_pkg::ADDR_W-1:0] i_raddr,
    output rpps_pkg::t_point       o_rdata
);
    import rpps_pkg::*;

    t_point r_mem [MAX_POINTS];
    t_point r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/rpps_classify.sv
// Separator, spike and elide detection on the incoming point and the two topmost stack points.
module rpps_classify (
    input  rpps_pkg::t_point   i_p0,
    input  rpps_pkg::t_point   i_p1,
    input  rpps_pkg::t_point   i_p2,
    output rpps_pkg::t_verdict o_verdict
);
    import rpps_pkg::*;

    t_coord x0, x1, x2, y0, y1, y2;
    logic   same_x, same_y, hit_x, hit_y, elide_x, elide_y;

    always_comb begin
        x0 = $signed(i_p0.x);
        x1 = $signed(i_p1.x);
        x2 = $signed(i_p2.x);
        y0 = $signed(i_p0.y);
        y1 = $signed(i_p1.y);
        y2 = $signed(i_p2.y);
        same_x  = (x0 == x1) && (x1 == x2);
        same_y  = (y0 == y1) && (y1 == y2);
        elide_x = !is_trim(y0, y1, y2) && is_elide(y0, y1, y2);
        elide_y = !is_trim(x0, x1, x2) && is_elide(x0, x1, x2);
        hit_x   = same_x && (is_trim(y0, y1, y2) || is_elide(y0, y1, y2));
        hit_y   = same_y && (is_trim(x0, x1, x2) || is_elide(x0, x1, x2));
        o_verdict.sep   = (same_x && is_sep(y0, y1, y2)) || (same_y && is_sep(x0, x1, x2));
        o_verdict.spike = hit_x || hit_y;
        o_verdict.elide = hit_x ? elide_x : (hit_y && elide_y);
    end

endmodule

// File: sv/rectilinear_path_point_simplifier_core.sv
// Top level of the path point simplifier: stack control, memory access and stream ports.
// Each item is accepted in S_IDLE, where one stack memory read is issued; S_WORK then
// decides and writes back at most one entry once the result register is free. No new
// item is accepted until S_WORK has handed its result to the result register.
// Reset empties the stack and clears the control state; memory contents are not cleared.
module rectilinear_path_point_simplifier_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: x_coord, y_coord, read_index, zero fill.
    input  logic [rpps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: kind.
    input  logic [rpps_pkg::KIND_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: point_count, read_x, read_y, read_valid, zero fill.
    output logic [rpps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: action.
    output logic [rpps_pkg::ACTION_W-1:0]     m_axis_tuser
);
    import rpps_pkg::*;

    typedef enum logic {S_IDLE, S_WORK} t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_count;
    t_point                r_top;
    logic [KIND_W-1:0]     r_kind;
    t_point                r_pt;
    logic [IDX_W-1:0]      r_idx;

    logic                  r_out_valid;
    logic [ACTION_W-1:0]   r_out_action;
    logic [CNT_W-1:0]      r_out_count;
    t_point                r_out_rd;
    logic                  r_out_rv;

    logic                  in_acc, out_free, work_go;
    logic [ACTION_W-1:0]   n_action;
    logic [CNT_W-1:0]      n_count;
    t_point                n_top;
    t_point                n_rd;
    logic                  n_rv;
    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    t_point                mem_rdata;
    t_verdict              verdict;
    t_point                in_pt;
    logic [IDX_W-1:0]      in_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign work_go       = (r_state == S_WORK) && out_free;

    assign in_pt.x = s_axis_tdata[COORD_BITS-1:0];
    assign in_pt.y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign in_idx  = s_axis_tdata[2*COORD_BITS+IDX_W-1:2*COORD_BITS];

    assign mem_re    = in_acc;
    assign mem_raddr = (s_axis_tuser == KIND_APPEND) ? ADDR_W'(r_count - CNT_W'(2))
                                                     : ADDR_W'(in_idx);

    rpps_stack_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_pt),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rpps_classify u_classify (
        .i_p0      (r_pt),
        .i_p1      (r_top),
        .i_p2      (mem_rdata),
        .o_verdict (verdict)
    );

    always_comb begin
        n_action  = ACT_READ;
        n_count   = r_count;
        n_top     = r_top;
        n_rd      = '0;
        n_rv      = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(r_count);
        case (r_kind)
            KIND_APPEND: begin
                if ((r_count != '0) && (r_top == r_pt)) begin
                    n_action = ACT_DUPLICATE;
                end else if (r_count >= CNT_W'(MAX_POINTS)) begin
                    n_action = ACT_OVERFLOW;
                end else if ((r_count >= CNT_W'(2)) && (verdict.sep || verdict.spike)) begin
                    if (verdict.sep || !verdict.elide) begin
                        n_action  = verdict.sep ? ACT_SEPARATOR : ACT_TRIMMED;
                        mem_we    = work_go;
                        mem_waddr = ADDR_W'(r_count - CNT_W'(1));
                        n_top     = r_pt;
                    end else begin
                        n_action = ACT_ELIDED;
                        n_count  = r_count - CNT_W'(1);
                        n_top    = mem_rdata;
                    end
                end else begin
                    n_action = ACT_APPENDED;
                    mem_we   = work_go;
                    n_count  = r_count + CNT_W'(1);
                    n_top    = r_pt;
                end
            end
            KIND_CLEAR: begin
                n_action = ACT_CLEARED;
                n_count  = '0;
            end
            default: begin
                n_action = ACT_READ;
                if (CNT_W'(r_idx) < r_count) begin
                    n_rd = mem_rdata;
                    n_rv = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state <= S_WORK;
            end else if (work_go) begin
                r_state <= S_IDLE;
            end
            if (work_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_kind <= s_axis_tuser;
                r_pt   <= in_pt;
                r_idx  <= in_idx;
            end
            if (work_go) begin
                r_top        <= n_top;
                r_out_action <= n_action;
                r_out_count  <= n_count;
                r_out_rd     <= n_rd;
                r_out_rv     <= n_rv;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_action;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_rv, r_out_rd.y, r_out_rd.x,
                                        COUNT_OUT_W'(r_out_count)});

endmodule

// File: sv/rpps_checker.sv
// Port-level assertions for the path point simplifier and their binding to the top level.
module rpps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rpps_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic [rpps_pkg::ACTION_W-1:0]   m_axis_tuser
);
    import rpps_pkg::*;

    localparam int RV_BIT = COUNT_OUT_W + 2 * COORD_BITS;

    logic [COUNT_OUT_W-1:0] cnt;
    logic                   rv;

    assign cnt = m_axis_tdata[COUNT_OUT_W-1:0];
    assign rv  = m_axis_tdata[RV_BIT];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
        $stable(m_axis_tuser))
        else $error("Result changed while stalled.");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> cnt <= COUNT_OUT_W'(MAX_POINTS))
        else $error("Point count above capacity.");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ACT_CLEARED) |-> cnt == '0)
        else $error("Clear left points on the stack.");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !rv |-> m_axis_tdata[RV_BIT-1:COUNT_OUT_W] == '0)
        else $error("Read coordinates set without a valid read.");

    a_rv_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && rv |-> m_axis_tuser == ACT_READ)
        else $error("Read valid on an item that is not a read.");

endmodule

bind rectilinear_path_point_simplifier_core rpps_checker u_rpps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
